// ===== rtl/core/btm_pkg.sv =====
package btm_pkg;

  localparam int unsigned FIELD_BITS_MAX = 64;
  localparam int unsigned FIELD_BITS_DEF = 64;
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned PADDR_W        = 4;

  localparam logic [DATA_W-1:0] RESET_MODULUS  = 64'd9223372036855300097;
  localparam logic [DATA_W-1:0] RESET_HALF_INV = 64'd4611686018427650049;

  typedef enum logic {
    REG_FIELD_MODULUS = 1'b0,
    REG_HALF_INVERSE  = 1'b1
  } reg_idx_e;

  // operands below p, zero-extended into the 64-bit frame
  function automatic logic [FIELD_BITS_MAX-1:0] mod_add(input logic [FIELD_BITS_MAX-1:0] a,
                                                        input logic [FIELD_BITS_MAX-1:0] b,
                                                        input logic [FIELD_BITS_MAX-1:0] p);
    logic [FIELD_BITS_MAX:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[FIELD_BITS_MAX-1:0];
  endfunction

  function automatic logic [FIELD_BITS_MAX-1:0] mod_sub(input logic [FIELD_BITS_MAX-1:0] a,
                                                        input logic [FIELD_BITS_MAX-1:0] b,
                                                        input logic [FIELD_BITS_MAX-1:0] p);
    logic [FIELD_BITS_MAX-1:0] r;
    r = a - b;
    if (a < b) begin
      r = r + p;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/btm_in_if.sv =====
interface btm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] first_d_share;
  logic [63:0] second_d_share;
  logic [63:0] first_e_share;
  logic [63:0] second_e_share;
  logic [63:0] triple_a;
  logic [63:0] triple_b;
  logic [63:0] triple_c;
  logic [63:0] h_at_point;

  modport source (output valid, first_d_share, second_d_share, first_e_share, second_e_share,
                  triple_a, triple_b, triple_c, h_at_point, input ready);
  modport sink (input valid, first_d_share, second_d_share, first_e_share, second_e_share,
                triple_a, triple_b, triple_c, h_at_point, output ready);
endinterface

// ===== rtl/core/btm_out_if.sv =====
interface btm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] output_share;

  modport source (output valid, output_share, input ready);
  modport sink (input valid, output_share, output ready);
endinterface

// ===== rtl/core/btm_reduce.sv =====
module btm_reduce #(
  parameter int unsigned W     = btm_pkg::FIELD_BITS_DEF,
  parameter int unsigned LANES = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [W-1:0]              p_i,
  input  logic [LANES-1:0][W-1:0]   x_i,
  output logic                      valid_o,
  output logic [LANES-1:0][W-1:0]   r_o
);
  import btm_pkg::*;

  logic [W-1:0][LANES-1:0][W-1:0] r_q;
  logic [W-1:0][LANES-1:0][W-1:0] x_q;
  logic [W-1:0]                   v_q;

  // one bit of Horner reduction per stage, msb first
  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [LANES-1:0][W-1:0] r_in, x_in, r_d, x_d;
    logic                    v_in;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign x_in = x_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign r_in = r_q[s-1];
      assign x_in = x_q[s-1];
      assign v_in = v_q[s-1];
    end

    always_comb begin
      logic [W:0] t;
      for (int l = 0; l < LANES; l++) begin
        t = {r_in[l], x_in[l][W-1]};
        if (t >= {1'b0, p_i}) begin
          t = t - {1'b0, p_i};
        end
        r_d[l] = t[W-1:0];
        x_d[l] = {x_in[l][W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s] <= r_d;
        x_q[s] <= x_d;
      end
    end
  end

  assign valid_o = v_q[W-1];
  assign r_o     = r_q[W-1];

endmodule

// ===== rtl/core/btm_mulpipe.sv =====
module btm_mulpipe #(
  parameter int unsigned W     = btm_pkg::FIELD_BITS_DEF,
  parameter int unsigned LANES = 3,
  parameter int unsigned SW    = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [W-1:0]              p_i,
  input  logic [LANES-1:0][W-1:0]   x_i,
  input  logic [LANES-1:0][W-1:0]   y_i,
  input  logic [SW-1:0]             side_i,
  output logic                      valid_o,
  output logic [LANES-1:0][W-1:0]   prod_o,
  output logic [SW-1:0]             side_o
);
  import btm_pkg::*;

  logic [W-1:0][LANES-1:0][W-1:0] r_q, x_q, y_q;
  logic [W-1:0][SW-1:0]           side_q;
  logic [W-1:0]                   v_q;

  logic [FIELD_BITS_MAX-1:0] p_ext;
  assign p_ext = FIELD_BITS_MAX'(p_i);

  // double-and-add, one multiplier bit per stage, msb first
  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [LANES-1:0][W-1:0] r_in, x_in, y_in, r_d;
    logic [SW-1:0]           side_in;
    logic                    v_in;

    if (s == 0) begin : g_first
      assign r_in    = '0;
      assign x_in    = x_i;
      assign y_in    = y_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign r_in    = r_q[s-1];
      assign x_in    = x_q[s-1];
      assign y_in    = y_q[s-1];
      assign side_in = side_q[s-1];
      assign v_in    = v_q[s-1];
    end

    always_comb begin
      logic [FIELD_BITS_MAX-1:0] t;
      for (int l = 0; l < LANES; l++) begin
        t = mod_add(FIELD_BITS_MAX'(r_in[l]), FIELD_BITS_MAX'(r_in[l]), p_ext);
        if (y_in[l][W-1-s]) begin
          t = mod_add(t, FIELD_BITS_MAX'(x_in[l]), p_ext);
        end
        r_d[l] = t[W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]    <= r_d;
        x_q[s]    <= x_in;
        y_q[s]    <= y_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[W-1];
  assign prod_o  = r_q[W-1];
  assign side_o  = side_q[W-1];

endmodule

// ===== rtl/core/beaver_triple_mult_check_modp_core.sv =====
// Beaver triple multiplication share, modulo a configurable prime p.
// Input channel in_i carries both servers' shares of d and e, this server's
// triple shares a, b, c and its share of h(r). Output channel out_o carries
// output_share = d*e*inv2 + d*b + e*a + c - h mod p, one per input transfer,
// in order. Inputs and the half inverse are first reduced modulo p; p of zero
// gives zero.
// The pipeline has one stage per bit for input reduction, for the three
// parallel products and for the product with inv2, plus four add stages.
// Throughput is one transfer per cycle.
// A stalled receiver freezes the whole pipeline; in_i.ready drops while the
// output register holds an untaken result.
// The APB port holds field_modulus at 0x0 and half_inverse at 0x8; write
// only while the pipeline is empty. Reset loads the default prime and its
// half inverse and clears all valid bits.
module beaver_triple_mult_check_modp_core #(
  parameter int unsigned FIELD_BITS = btm_pkg::FIELD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  btm_in_if.sink                      in_i,
  btm_out_if.source                   out_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [btm_pkg::PADDR_W-1:0] paddr_i,
  input  logic [btm_pkg::DATA_W-1:0]  pwdata_i,
  output logic [btm_pkg::DATA_W-1:0]  prdata_o,
  output logic                        pready_o
);
  import btm_pkg::*;

  localparam int unsigned W = FIELD_BITS;

  logic [DATA_W-1:0] modulus_q, half_inv_q;
  reg_idx_e          reg_sel;

  assign reg_sel  = reg_idx_e'(paddr_i[3]);
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= RESET_MODULUS;
      half_inv_q <= RESET_HALF_INV;
    end else if (psel_i && penable_i && pwrite_i) begin
      unique case (reg_sel)
        REG_FIELD_MODULUS: modulus_q  <= pwdata_i;
        REG_HALF_INVERSE:  half_inv_q <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIELD_MODULUS: prdata_o = modulus_q;
      REG_HALF_INVERSE:  prdata_o = half_inv_q;
      default:           prdata_o = '0;
    endcase
  end

  logic [W-1:0]              p;
  logic [FIELD_BITS_MAX-1:0] p_ext;
  logic                      en;
  logic                      out_valid_q;
  logic [W-1:0]              out_share_q;

  assign p     = modulus_q[W-1:0];
  assign p_ext = FIELD_BITS_MAX'(p);
  assign en    = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // input reduction
  logic [8:0][W-1:0] red_in, red_out;
  logic              red_valid;

  assign red_in[0] = in_i.first_d_share[W-1:0];
  assign red_in[1] = in_i.second_d_share[W-1:0];
  assign red_in[2] = in_i.first_e_share[W-1:0];
  assign red_in[3] = in_i.second_e_share[W-1:0];
  assign red_in[4] = in_i.triple_a[W-1:0];
  assign red_in[5] = in_i.triple_b[W-1:0];
  assign red_in[6] = in_i.triple_c[W-1:0];
  assign red_in[7] = in_i.h_at_point[W-1:0];
  assign red_in[8] = half_inv_q[W-1:0];

  btm_reduce #(.W(W), .LANES(9)) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid && en),
    .p_i     (p),
    .x_i     (red_in),
    .valid_o (red_valid),
    .r_o     (red_out)
  );

  // d and e sums
  logic         de_valid_q;
  logic [W-1:0] d_q, e_q, a_q, b_q, c_q, h_q, inv2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      de_valid_q <= 1'b0;
    end else if (en) begin
      de_valid_q <= red_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q    <= W'(mod_add(FIELD_BITS_MAX'(red_out[0]), FIELD_BITS_MAX'(red_out[1]), p_ext));
      e_q    <= W'(mod_add(FIELD_BITS_MAX'(red_out[2]), FIELD_BITS_MAX'(red_out[3]), p_ext));
      a_q    <= red_out[4];
      b_q    <= red_out[5];
      c_q    <= red_out[6];
      h_q    <= red_out[7];
      inv2_q <= red_out[8];
    end
  end

  // d*e, d*b, e*a
  logic [2:0][W-1:0] m1_x, m1_y, m1_p;
  logic [3*W-1:0]    m1_side;
  logic              m1_valid;

  assign m1_x = {e_q, d_q, d_q};
  assign m1_y = {a_q, b_q, e_q};

  btm_mulpipe #(.W(W), .LANES(3), .SW(3*W)) u_mul_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (de_valid_q),
    .p_i     (p),
    .x_i     (m1_x),
    .y_i     (m1_y),
    .side_i  ({c_q, h_q, inv2_q}),
    .valid_o (m1_valid),
    .prod_o  (m1_p),
    .side_o  (m1_side)
  );

  // cross terms summed
  logic         s_valid_q;
  logic [W-1:0] de_q, cross_q, c2_q, h2_q, inv2b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (en) begin
      s_valid_q <= m1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      de_q    <= m1_p[0];
      cross_q <= W'(mod_add(FIELD_BITS_MAX'(m1_p[1]), FIELD_BITS_MAX'(m1_p[2]), p_ext));
      c2_q    <= m1_side[3*W-1:2*W];
      h2_q    <= m1_side[2*W-1:W];
      inv2b_q <= m1_side[W-1:0];
    end
  end

  // d*e*inv2
  logic [0:0][W-1:0] m2_p;
  logic [3*W-1:0]    m2_side;
  logic              m2_valid;

  btm_mulpipe #(.W(W), .LANES(1), .SW(3*W)) u_mul_half (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid_q),
    .p_i     (p),
    .x_i     (de_q),
    .y_i     (inv2b_q),
    .side_i  ({cross_q, c2_q, h2_q}),
    .valid_o (m2_valid),
    .prod_o  (m2_p),
    .side_o  (m2_side)
  );

  // final sums
  logic         f_valid_q;
  logic [W-1:0] t_q, u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q   <= m2_valid;
      out_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q <= W'(mod_add(FIELD_BITS_MAX'(m2_p[0]), FIELD_BITS_MAX'(m2_side[3*W-1:2*W]), p_ext));
      u_q <= W'(mod_sub(FIELD_BITS_MAX'(m2_side[2*W-1:W]), FIELD_BITS_MAX'(m2_side[W-1:0]),
                        p_ext));
      if (p == '0) begin
        out_share_q <= '0;
      end else begin
        out_share_q <= W'(mod_add(FIELD_BITS_MAX'(t_q), FIELD_BITS_MAX'(u_q), p_ext));
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.output_share = DATA_W'(out_share_q);

endmodule
